>>> rtl/dmxfs_pkg.sv
// Package for the DMX512 frame sequencer.
// Holds the event and phase types, output phase codes and the result record.
// No dependencies.
package dmxfs_pkg;

  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_TICK  = 2'd1,
    EV_EMPTY = 2'd2,
    EV_DONE  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_BREAK   = 3'b010,
    PH_SENDING = 3'b100
  } phase_e;

  localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CODE_BREAK   = 2'd1;
  localparam logic [1:0] PHASE_CODE_SENDING = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic       send_valid;
    logic       from_mem;
    logic       break_rate;
    logic       frame_done;
    logic       bad_channel;
    logic [1:0] phase;
  } result_t;

endpackage

>>> rtl/dmxfs_level_ram.sv
// Channel level buffer for the DMX512 frame sequencer.
// One write port, one registered read port, and a zeroing sweep after reset.
// Depends on nothing outside this file.
module dmxfs_level_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  output logic          busy_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] clr_q, clr_d;
  logic          busy_q, busy_d;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

>>> rtl/dmx512_frame_sequencer.sv
// DMX512 frame sequencer, top level.
// Uses dmxfs_pkg and dmxfs_level_ram.
//
// Usage: one event per input transfer (func_i, channel_i, value_i); each
// event yields exactly one result transfer on the output channel, in order.
// A write stores a channel level, or flags bad_channel_o when the channel is
// at or beyond UNIVERSE_SIZE. A frame tick in idle sends the break byte at the
// break rate, transmit-complete in break sends the start code at the data
// rate, and each transmitter-empty while sending sends the next level; the one
// after the last level returns to idle with frame_done_o set.
// Path: an accepted event passes the pipeline stage and the output register
// before out_valid_o rises. Throughput: one event per cycle while in_ready_o
// is high; the level buffer is read when a level-sending event is taken,
// and its registered data joins that result as it enters the output register.
// Reset: a sweep zeroes all UNIVERSE_SIZE entries of the level buffer with
// in_ready_o low; phase returns to idle, channel counter to zero, data rate.
// Stall: the pipeline stage and the output register each hold one result, so
// one more event is taken while a result waits; then in_ready_o drops until
// out_ready_i returns.
module dmx512_frame_sequencer
  import dmxfs_pkg::*;
#(
  parameter int unsigned UNIVERSE_SIZE = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [9:0] channel_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       break_rate_o,
  output logic       frame_done_o,
  output logic       bad_channel_o,
  output logic [1:0] phase_o
);

  localparam int unsigned AW = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;
  localparam logic [10:0] UNI = 11'(UNIVERSE_SIZE);

  phase_e      phase_q, phase_d;
  logic [9:0]  next_ch_q, next_ch_d;
  logic        rate_q, rate_d;
  logic        accept;
  logic        rd_en, wr_en;
  logic [7:0]  rd_data;
  logic        ram_busy;
  result_t     res;
  result_t     s1_q;
  logic        s1_valid_q;
  logic        s1_adv;
  logic        out_valid_q;
  logic        send_valid_q, break_rate_q, frame_done_q, bad_channel_q;
  logic [7:0]  send_byte_q;
  logic [1:0]  phase_code_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ram_busy && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d   = phase_q;
    next_ch_d = next_ch_q;
    rate_d    = rate_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    res       = '0;
    unique case (event_e'(func_i))
      EV_WRITE: begin
        if ({1'b0, channel_i} < UNI) begin
          wr_en = accept;
        end else begin
          res.bad_channel = 1'b1;
        end
      end
      EV_TICK: begin
        if (phase_q == PH_IDLE) begin
          rate_d         = 1'b1;
          res.send_valid = 1'b1;
          phase_d        = PH_BREAK;
        end
      end
      EV_DONE: begin
        if (phase_q == PH_BREAK) begin
          next_ch_d      = '0;
          rate_d         = 1'b0;
          res.send_valid = 1'b1;
          phase_d        = PH_SENDING;
        end
      end
      EV_EMPTY: begin
        if (phase_q == PH_SENDING) begin
          if ({1'b0, next_ch_q} < UNI) begin
            res.send_valid = 1'b1;
            res.from_mem   = 1'b1;
            rd_en          = accept;
            next_ch_d      = next_ch_q + 10'd1;
          end else begin
            phase_d        = PH_IDLE;
            res.frame_done = 1'b1;
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    res.break_rate = rate_d;
    unique case (phase_d)
      PH_IDLE:    res.phase = PHASE_CODE_IDLE;
      PH_BREAK:   res.phase = PHASE_CODE_BREAK;
      PH_SENDING: res.phase = PHASE_CODE_SENDING;
      default:    res.phase = PHASE_CODE_IDLE;
    endcase
  end

  dmxfs_level_ram #(
    .DEPTH(UNIVERSE_SIZE),
    .AW   (AW)
  ) u_levels (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(next_ch_q[AW-1:0]),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(channel_i[AW-1:0]),
    .wr_data_i(value_i),
    .busy_o   (ram_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      next_ch_q   <= '0;
      rate_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        next_ch_q <= next_ch_d;
        rate_q    <= rate_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (s1_adv) begin
      send_valid_q  <= s1_q.send_valid;
      send_byte_q   <= s1_q.from_mem ? rd_data : BYTE_ZERO;
      break_rate_q  <= s1_q.break_rate;
      frame_done_q  <= s1_q.frame_done;
      bad_channel_q <= s1_q.bad_channel;
      phase_code_q  <= s1_q.phase;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign send_valid_o  = send_valid_q;
  assign send_byte_o   = send_byte_q;
  assign break_rate_o  = break_rate_q;
  assign frame_done_o  = frame_done_q;
  assign bad_channel_o = bad_channel_q;
  assign phase_o       = phase_code_q;

endmodule
